// ===== rtl/core/sampson_epipolar_distance_macros.svh =====
`ifndef SAMPSON_EPIPOLAR_DISTANCE_MACROS_SVH
`define SAMPSON_EPIPOLAR_DISTANCE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sed_pkg.sv =====
package sed_pkg;

  localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
  // 1.0e-15 rounded to binary32
  localparam logic [31:0] DEN_FLOOR   = 32'h2690_1D7D;

  localparam logic [2:0] CFG_PAIR_A = 3'd0;
  localparam logic [2:0] CFG_PAIR_B = 3'd1;
  localparam logic [2:0] CFG_PAIR_C = 3'd2;
  localparam logic [2:0] CFG_PAIR_D = 3'd3;
  localparam logic [2:0] CFG_LAST   = 3'd4;

  typedef struct packed {
    logic [31:0] src_x;
    logic [31:0] src_y;
    logic [31:0] dst_x;
    logic [31:0] dst_y;
  } sed_in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        degenerate;
  } sed_out_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sgn;
  } sed_spec_t;

  function automatic logic [5:0] lzc52(input logic [51:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) n = 6'(51 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // value = m * 2^e, rounded to nearest even binary32
  function automatic logic [31:0] round_pack(input logic sgn, input logic [51:0] m,
                                             input logic signed [11:0] e);
    logic [5:0]         lz;
    logic [51:0]        nm;
    logic [51:0]        sh;
    logic signed [11:0] be;
    logic signed [11:0] amt;
    logic               stk;
    logic               rb;
    logic               up;
    logic [23:0]        sig;
    logic [7:0]         ef;
    lz  = lzc52(m);
    nm  = m << lz;
    be  = e + 12'sd178 - $signed({6'd0, lz});
    sh  = nm;
    stk = 1'b0;
    amt = 12'sd1 - be;
    if (be < 12'sd1) begin
      if (amt >= 12'sd52) begin
        sh  = '0;
        stk = |nm;
      end else begin
        sh  = nm >> amt[5:0];
        stk = |(nm & ~({52{1'b1}} << amt[5:0]));
      end
    end
    sig = sh[51:28];
    rb  = sh[27];
    stk = stk | (|sh[26:0]);
    up  = rb & (stk | sig[0]);
    ef  = (be > 12'sd0) ? be[7:0] : 8'd0;
    if (m == '0) return {sgn, 31'd0};
    else if (be > 12'sd254) return {sgn, F32_POS_INF[30:0]};
    else return {sgn, {ef, sig[22:0]} + {30'd0, up}};
  endfunction

  function automatic logic [31:0] pack_result(input sed_spec_t s, input logic [51:0] m,
                                              input logic signed [11:0] e);
    if (s.nan) return F32_QNAN;
    else if (s.inf) return {s.sgn, F32_POS_INF[30:0]};
    else if (s.zero) return {s.sgn, 31'd0};
    else return round_pack(s.sgn, m, e);
  endfunction

endpackage

// ===== rtl/core/sed_fmul.sv =====
module sed_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] y
);

  logic [7:0]         a_ef, b_ef;
  logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic signed [11:0] ea, eb;
  logic [23:0]        ma, mb;
  sed_pkg::sed_spec_t spec_c;

  logic               vld_a;
  sed_pkg::sed_spec_t spec;
  logic [47:0]        prod;
  logic signed [11:0] e;

  always_comb begin
    a_ef   = a[30:23];
    b_ef   = b[30:23];
    a_nan  = (&a_ef) & (|a[22:0]);
    b_nan  = (&b_ef) & (|b[22:0]);
    a_inf  = (&a_ef) & ~(|a[22:0]);
    b_inf  = (&b_ef) & ~(|b[22:0]);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma     = {|a_ef, a[22:0]};
    mb     = {|b_ef, b[22:0]};
    ea     = $signed({4'd0, (|a_ef) ? a_ef : 8'd1}) - 12'sd150;
    eb     = $signed({4'd0, (|b_ef) ? b_ef : 8'd1}) - 12'sd150;
    spec_c.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    spec_c.inf  = a_inf | b_inf;
    spec_c.zero = 1'b0;
    spec_c.sgn  = a[31] ^ b[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_a   <= vld;
      out_vld <= vld_a;
    end
    spec <= spec_c;
    prod <= ma * mb;
    e    <= ea + eb;
    y    <= sed_pkg::pack_result(spec, {4'd0, prod}, e);
  end

endmodule

// ===== rtl/core/sed_fadd.sv =====
module sed_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] y
);

  logic               a_big;
  logic [31:0]        hi, lo;
  logic [7:0]         he, le, d;
  logic [49:0]        hm, lm, al;
  logic [50:0]        sum;
  logic               a_nan, a_inf, b_nan, b_inf;
  sed_pkg::sed_spec_t spec_c;

  logic               vld_a;
  sed_pkg::sed_spec_t spec;
  logic [51:0]        m;
  logic signed [11:0] e;

  always_comb begin
    a_nan = (&a[30:23]) & (|a[22:0]);
    b_nan = (&b[30:23]) & (|b[22:0]);
    a_inf = (&a[30:23]) & ~(|a[22:0]);
    b_inf = (&b[30:23]) & ~(|b[22:0]);
    a_big = (a[30:0] >= b[30:0]);
    hi    = a_big ? a : b;
    lo    = a_big ? b : a;
    he    = (|hi[30:23]) ? hi[30:23] : 8'd1;
    le    = (|lo[30:23]) ? lo[30:23] : 8'd1;
    d     = he - le;
    hm    = {|hi[30:23], hi[22:0], 26'd0};
    lm    = {|lo[30:23], lo[22:0], 26'd0};
    if (d >= 8'd50) begin
      al = {49'd0, |lm};
    end else begin
      al = (lm >> d[5:0]) | {49'd0, |(lm & ~({50{1'b1}} << d[5:0]))};
    end
    if (hi[31] == lo[31]) sum = {1'b0, hm} + {1'b0, al};
    else sum = {1'b0, hm} - {1'b0, al};
    spec_c.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    spec_c.inf  = a_inf | b_inf;
    spec_c.zero = 1'b0;
    if (a_inf) spec_c.sgn = a[31];
    else if (b_inf) spec_c.sgn = b[31];
    else if (sum == '0) spec_c.sgn = a[31] & b[31];
    else spec_c.sgn = hi[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_a   <= vld;
      out_vld <= vld_a;
    end
    spec <= spec_c;
    m    <= {1'b0, sum};
    e    <= $signed({4'd0, he}) - 12'sd176;
    y    <= sed_pkg::pack_result(spec, m, e);
  end

endmodule

// ===== rtl/core/sed_fdiv.sv =====
module sed_fdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_vld,
  output logic [31:0] q
);

  localparam int unsigned STEPS = 27;

  typedef struct packed {
    sed_pkg::sed_spec_t spec;
    logic signed [11:0] e;
    logic [23:0]        md;
    logic [24:0]        rem;
    logic [26:0]        quo;
  } div_stage_t;

  logic               n_nan, n_inf, n_zero, d_nan, d_inf, d_zero;
  logic [23:0]        nf, df;
  logic [4:0]         lzn, lzd;
  logic signed [11:0] en, ed;
  div_stage_t         prep;

  div_stage_t         st [STEPS+1];
  logic [STEPS:0]     sv;
  logic [24:0]        t [STEPS];
  logic [STEPS-1:0]   qb;

  always_comb begin
    n_nan  = (&num[30:23]) & (|num[22:0]);
    d_nan  = (&den[30:23]) & (|den[22:0]);
    n_inf  = (&num[30:23]) & ~(|num[22:0]);
    d_inf  = (&den[30:23]) & ~(|den[22:0]);
    n_zero = (num[30:0] == '0);
    d_zero = (den[30:0] == '0);
    nf     = {|num[30:23], num[22:0]};
    df     = {|den[30:23], den[22:0]};
    lzn    = sed_pkg::lzc24(nf);
    lzd    = sed_pkg::lzc24(df);
    en     = $signed({4'd0, (|num[30:23]) ? num[30:23] : 8'd1}) - 12'sd150
             - $signed({7'd0, lzn});
    ed     = $signed({4'd0, (|den[30:23]) ? den[30:23] : 8'd1}) - 12'sd150
             - $signed({7'd0, lzd});
    prep.spec.nan  = n_nan | d_nan | (n_inf & d_inf) | (n_zero & d_zero);
    prep.spec.inf  = n_inf | d_zero;
    prep.spec.zero = n_zero | d_inf;
    prep.spec.sgn  = num[31] ^ den[31];
    prep.e         = en - ed - 12'sd27;
    prep.md        = df << lzd;
    prep.rem       = {1'b0, nf << lzn};
    prep.quo       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= vld;
    st[0] <= prep;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign t[k] = st[k].rem;
    end else begin : g_next
      assign t[k] = {st[k].rem[23:0], 1'b0};
    end
    assign qb[k] = (t[k] >= {1'b0, st[k].md});

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      st[k+1].spec <= st[k].spec;
      st[k+1].e    <= st[k].e;
      st[k+1].md   <= st[k].md;
      st[k+1].rem  <= qb[k] ? (t[k] - {1'b0, st[k].md}) : t[k];
      st[k+1].quo  <= {st[k].quo[25:0], qb[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= sv[STEPS];
    q <= sed_pkg::pack_result(st[STEPS].spec,
                              {24'd0, st[STEPS].quo, |st[STEPS].rem}, st[STEPS].e);
  end

endmodule

// ===== rtl/core/sed_fsqrt.sv =====
module sed_fsqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld,
  input  logic [31:0] a,
  output logic        out_vld,
  output logic [31:0] y
);

  localparam int unsigned STEPS = 25;

  typedef struct packed {
    logic        byp;
    logic [31:0] bval;
    logic [7:0]  fe;
    logic [49:0] big;
    logic [27:0] rem;
    logic [24:0] root;
  } sq_stage_t;

  logic [23:0]        f24;
  logic [23:0]        mn;
  logic [4:0]         lz;
  logic signed [11:0] e, sh, fe12;
  sq_stage_t          prep;

  sq_stage_t          st [STEPS+1];
  logic [STEPS:0]     sv;
  logic [27:0]        r2 [STEPS];
  logic [27:0]        trial [STEPS];
  logic [STEPS-1:0]   ge;

  logic [24:0]        mant;
  logic               up;
  logic [7:0]         fe_out;
  logic [24:0]        mant_r;

  always_comb begin
    f24  = {|a[30:23], a[22:0]};
    lz   = sed_pkg::lzc24(f24);
    mn   = f24 << lz;
    e    = $signed({4'd0, (|a[30:23]) ? a[30:23] : 8'd1}) - 12'sd150
           - $signed({7'd0, lz});
    sh   = e[0] ? 12'sd25 : 12'sd26;
    fe12 = ((e - sh) >>> 1) + 12'sd151;
    prep.fe   = fe12[7:0];
    prep.big  = e[0] ? {1'b0, mn, 25'd0} : {mn, 26'd0};
    prep.rem  = '0;
    prep.root = '0;
    if (&a[30:23]) begin
      prep.byp  = 1'b1;
      prep.bval = (|a[22:0]) ? sed_pkg::F32_QNAN : sed_pkg::F32_POS_INF;
    end else if (a[31] || (a[30:0] == '0)) begin
      prep.byp  = 1'b1;
      prep.bval = '0;
    end else begin
      prep.byp  = 1'b0;
      prep.bval = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= vld;
    st[0] <= prep;
  end

  // one root bit per stage, two radicand bits consumed
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    assign r2[k]    = {st[k].rem[25:0], st[k].big[49:48]};
    assign trial[k] = {1'b0, st[k].root, 2'b01};
    assign ge[k]    = (r2[k] >= trial[k]);

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      st[k+1].byp  <= st[k].byp;
      st[k+1].bval <= st[k].bval;
      st[k+1].fe   <= st[k].fe;
      st[k+1].big  <= {st[k].big[47:0], 2'b00};
      st[k+1].rem  <= ge[k] ? (r2[k] - trial[k]) : r2[k];
      st[k+1].root <= {st[k].root[23:0], ge[k]};
    end
  end

  always_comb begin
    up     = st[STEPS].root[0] & ((|st[STEPS].rem) | st[STEPS].root[1]);
    mant   = {1'b0, st[STEPS].root[24:1]} + {24'd0, up};
    fe_out = mant[24] ? (st[STEPS].fe + 8'd1) : st[STEPS].fe;
    mant_r = mant[24] ? (mant >> 1) : mant;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= sv[STEPS];
    y <= st[STEPS].byp ? st[STEPS].bval : {1'b0, fe_out, mant_r[22:0]};
  end

endmodule

// ===== rtl/core/sampson_epipolar_distance.sv =====
// Sampson distance of point correspondences against a 3x3 fundamental matrix.
// Matrix entries are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while the block is idle, as the block itself does not
// enforce it. Index 0..3 carry two binary32 entries each, index 4 the last.
// An item (src/dst point, binary32) is taken at a clock edge with start high
// and busy low. busy is high only during reset, so one item per cycle can
// enter, back to back. Each item gives one result on the result port,
// marked by done for one cycle, after passing through the registered
// multipliers and adders, the divider (one quotient bit per stage), the
// square root (one root bit per stage) and the output register. Results
// leave in input order and cannot be held off. Reset clears the matrix to
// zero and drops any item in flight. A denominator that is NaN, infinite,
// negative or at most 1e-15 gives +infinity with degenerate set.
`include "sampson_epipolar_distance_macros.svh"

module sampson_epipolar_distance (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sed_pkg::sed_in_t  corr,
  output logic              done,
  output sed_pkg::sed_out_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int unsigned LATENCY = 71;
  localparam int unsigned DG_LEN  = 56;

  logic [63:0] coef_pair_a, coef_pair_b, coef_pair_c, coef_pair_d;
  logic [31:0] coef_last;
  logic        acc;

  logic [31:0] f0x0, f1y0, f3x0, f4y0, f6x0, f7y0, f0x1, f3y1, f1x1, f4y1;
  logic [31:0] s_a0, s_a1, s_a2, s_b0, s_b1;
  logic [31:0] a0, a1, a2, b0, b1;
  logic [31:0] x1a0, y1a1, a0sq, a1sq, b0sq, b1sq;
  logic [31:0] t_sum, d1, num, d2, n2, d3, quo, root;
  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic        dg;

  logic [31:0] x1_dly [6];
  logic [31:0] y1_dly [6];
  logic [31:0] a2_dly [4];
  logic [31:0] b0sq_dly [2];
  logic [31:0] b1sq_dly [4];
  logic [DG_LEN-1:0] dg_pipe;

  assign busy = rst;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_pair_a <= '0;
      coef_pair_b <= '0;
      coef_pair_c <= '0;
      coef_pair_d <= '0;
      coef_last   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sed_pkg::CFG_PAIR_A: coef_pair_a <= cfg_data;
        sed_pkg::CFG_PAIR_B: coef_pair_b <= cfg_data;
        sed_pkg::CFG_PAIR_C: coef_pair_c <= cfg_data;
        sed_pkg::CFG_PAIR_D: coef_pair_d <= cfg_data;
        sed_pkg::CFG_LAST:   coef_last   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // F*p0 and F^T*p1 products
  sed_fmul u_m0 (.clk, .rst, .vld(acc), .a(coef_pair_a[31:0]), .b(corr.src_x),
                 .out_vld(v1), .y(f0x0));
  sed_fmul u_m1 (.clk, .rst, .vld(acc), .a(coef_pair_a[63:32]), .b(corr.src_y),
                 .out_vld(), .y(f1y0));
  sed_fmul u_m2 (.clk, .rst, .vld(acc), .a(coef_pair_b[63:32]), .b(corr.src_x),
                 .out_vld(), .y(f3x0));
  sed_fmul u_m3 (.clk, .rst, .vld(acc), .a(coef_pair_c[31:0]), .b(corr.src_y),
                 .out_vld(), .y(f4y0));
  sed_fmul u_m4 (.clk, .rst, .vld(acc), .a(coef_pair_d[31:0]), .b(corr.src_x),
                 .out_vld(), .y(f6x0));
  sed_fmul u_m5 (.clk, .rst, .vld(acc), .a(coef_pair_d[63:32]), .b(corr.src_y),
                 .out_vld(), .y(f7y0));
  sed_fmul u_m6 (.clk, .rst, .vld(acc), .a(coef_pair_a[31:0]), .b(corr.dst_x),
                 .out_vld(), .y(f0x1));
  sed_fmul u_m7 (.clk, .rst, .vld(acc), .a(coef_pair_b[63:32]), .b(corr.dst_y),
                 .out_vld(), .y(f3y1));
  sed_fmul u_m8 (.clk, .rst, .vld(acc), .a(coef_pair_a[63:32]), .b(corr.dst_x),
                 .out_vld(), .y(f1x1));
  sed_fmul u_m9 (.clk, .rst, .vld(acc), .a(coef_pair_c[31:0]), .b(corr.dst_y),
                 .out_vld(), .y(f4y1));

  sed_fadd u_s0 (.clk, .rst, .vld(v1), .a(f0x0), .b(f1y0), .out_vld(v2), .y(s_a0));
  sed_fadd u_s1 (.clk, .rst, .vld(v1), .a(f3x0), .b(f4y0), .out_vld(), .y(s_a1));
  sed_fadd u_s2 (.clk, .rst, .vld(v1), .a(f6x0), .b(f7y0), .out_vld(), .y(s_a2));
  sed_fadd u_s3 (.clk, .rst, .vld(v1), .a(f0x1), .b(f3y1), .out_vld(), .y(s_b0));
  sed_fadd u_s4 (.clk, .rst, .vld(v1), .a(f1x1), .b(f4y1), .out_vld(), .y(s_b1));

  sed_fadd u_c0 (.clk, .rst, .vld(v2), .a(s_a0), .b(coef_pair_b[31:0]),
                 .out_vld(v3), .y(a0));
  sed_fadd u_c1 (.clk, .rst, .vld(v2), .a(s_a1), .b(coef_pair_c[63:32]),
                 .out_vld(), .y(a1));
  sed_fadd u_c2 (.clk, .rst, .vld(v2), .a(s_a2), .b(coef_last),
                 .out_vld(), .y(a2));
  sed_fadd u_c3 (.clk, .rst, .vld(v2), .a(s_b0), .b(coef_pair_d[31:0]),
                 .out_vld(), .y(b0));
  sed_fadd u_c4 (.clk, .rst, .vld(v2), .a(s_b1), .b(coef_pair_d[63:32]),
                 .out_vld(), .y(b1));

  // residual terms and gradient squares
  sed_fmul u_r0 (.clk, .rst, .vld(v3), .a(x1_dly[5]), .b(a0), .out_vld(v4), .y(x1a0));
  sed_fmul u_r1 (.clk, .rst, .vld(v3), .a(y1_dly[5]), .b(a1), .out_vld(), .y(y1a1));
  sed_fmul u_q0 (.clk, .rst, .vld(v3), .a(a0), .b(a0), .out_vld(), .y(a0sq));
  sed_fmul u_q1 (.clk, .rst, .vld(v3), .a(a1), .b(a1), .out_vld(), .y(a1sq));
  sed_fmul u_q2 (.clk, .rst, .vld(v3), .a(b0), .b(b0), .out_vld(), .y(b0sq));
  sed_fmul u_q3 (.clk, .rst, .vld(v3), .a(b1), .b(b1), .out_vld(), .y(b1sq));

  sed_fadd u_t0 (.clk, .rst, .vld(v4), .a(x1a0), .b(y1a1), .out_vld(v5), .y(t_sum));
  sed_fadd u_d1 (.clk, .rst, .vld(v4), .a(a0sq), .b(a1sq), .out_vld(), .y(d1));

  sed_fadd u_t1 (.clk, .rst, .vld(v5), .a(t_sum), .b(a2_dly[3]), .out_vld(v6), .y(num));
  sed_fadd u_d2 (.clk, .rst, .vld(v5), .a(d1), .b(b0sq_dly[1]), .out_vld(), .y(d2));

  sed_fmul u_n2 (.clk, .rst, .vld(v6), .a(num), .b(num), .out_vld(v7), .y(n2));
  sed_fadd u_d3 (.clk, .rst, .vld(v6), .a(d2), .b(b1sq_dly[3]), .out_vld(), .y(d3));

  sed_fdiv u_div (.clk, .rst, .vld(v7), .num(n2), .den(d3), .out_vld(v8), .q(quo));

  sed_fsqrt u_sqrt (.clk, .rst, .vld(v8), .a(quo), .out_vld(v9), .y(root));

  assign dg = (&d3[30:23]) | d3[31] | (d3[30:0] <= sed_pkg::DEN_FLOOR[30:0]);

  always_ff @(posedge clk) begin
    x1_dly[0]   <= corr.dst_x;
    y1_dly[0]   <= corr.dst_y;
    for (int i = 1; i < 6; i++) begin
      x1_dly[i] <= x1_dly[i-1];
      y1_dly[i] <= y1_dly[i-1];
    end
    a2_dly[0]   <= a2;
    b1sq_dly[0] <= b1sq;
    for (int i = 1; i < 4; i++) begin
      a2_dly[i]   <= a2_dly[i-1];
      b1sq_dly[i] <= b1sq_dly[i-1];
    end
    b0sq_dly[0] <= b0sq;
    b0sq_dly[1] <= b0sq_dly[0];
    dg_pipe     <= {dg_pipe[DG_LEN-2:0], dg};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v9;
    result.degenerate <= dg_pipe[DG_LEN-1];
    result.distance   <= dg_pipe[DG_LEN-1] ? sed_pkg::F32_POS_INF : root;
  end

  `SED_ASSERT_NOW(a_degen_inf, done && result.degenerate, result.distance == sed_pkg::F32_POS_INF, "degenerate item without +inf distance")
  `SED_ASSERT_NOW(a_dist_pos, done, !result.distance[31], "negative distance")
  `SED_ASSERT_NOW(a_latency, done, $past(start && !busy, LATENCY), "result without matching item")

endmodule

// ===== tb/sv/sampson_epipolar_distance_tb.sv =====
`timescale 1ns / 1ps

module sampson_epipolar_distance_tb;

  localparam int DRAIN_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 110;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  sed_pkg::sed_in_t   corr = '0;
  logic      done;
  sed_pkg::sed_out_t  result;
  logic      cfg_we = 1'b0;
  logic [2:0]  cfg_index = sed_pkg::CFG_PAIR_A;
  logic [63:0] cfg_data = '0;

  sampson_epipolar_distance i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .corr(corr), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    sed_pkg::sed_in_t  pt;
    bit                typed;
    sed_pkg::sed_out_t want;
  } corr_row_t;

  logic [31:0]       fmat [9];
  sed_pkg::sed_out_t dist_q [$];
  int                fails = 0;
  int                n_items = 0;
  int                n_results = 0;
  int                n_degen = 0;
  int                idle_cycles = 0;
  bit                cur_typed = 1'b0;
  sed_pkg::sed_out_t cur_want = '0;

  // binary32 <-> real; real ops on binary32 operands round correctly once narrowed
  function automatic real f32_real(input logic [31:0] b);
    logic [63:0] d;
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, b[22:0], 29'd0};
    end else if (b[30:23] == 8'd0) begin
      d = {1'b0, 11'(1023 - 149), 52'd0};
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * $bitstoreal(d);
    end else begin
      d = {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] real_f32(input real r);
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] sh;
    logic [23:0] keep;
    logic        stk;
    logic        up;
    logic [7:0]  ef;
    int          e;
    int          amt;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], sed_pkg::F32_POS_INF[30:0]};
    v = {1'b1, d[51:0], 11'd0};
    amt = (e >= -126) ? 0 : -126 - e;
    if (amt >= 64) begin
      sh = '0;
      stk = 1'b1;
    end else begin
      sh = v >> amt;
      stk = |(v & ~({64{1'b1}} << amt));
    end
    keep = sh[63:40];
    stk = stk | (|sh[38:0]);
    up = sh[39] & (stk | keep[0]);
    ef = (e >= -126) ? 8'(e + 127) : 8'd0;
    return {d[63], {ef, keep[22:0]} + {30'd0, up}};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    return real_f32(f32_real(a) * f32_real(b));
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    return real_f32(f32_real(a) + f32_real(b));
  endfunction

  function automatic sed_pkg::sed_out_t sampson_predict(input sed_pkg::sed_in_t c);
    logic [31:0]       a0, a1, a2, b0, b1, num, den, q;
    sed_pkg::sed_out_t o;
    a0 = fadd(fadd(fmul(fmat[0], c.src_x), fmul(fmat[1], c.src_y)), fmat[2]);
    a1 = fadd(fadd(fmul(fmat[3], c.src_x), fmul(fmat[4], c.src_y)), fmat[5]);
    a2 = fadd(fadd(fmul(fmat[6], c.src_x), fmul(fmat[7], c.src_y)), fmat[8]);
    b0 = fadd(fadd(fmul(fmat[0], c.dst_x), fmul(fmat[3], c.dst_y)), fmat[6]);
    b1 = fadd(fadd(fmul(fmat[1], c.dst_x), fmul(fmat[4], c.dst_y)), fmat[7]);
    num = fadd(fadd(fmul(c.dst_x, a0), fmul(c.dst_y, a1)), a2);
    den = fadd(fadd(fadd(fmul(a0, a0), fmul(a1, a1)), fmul(b0, b0)), fmul(b1, b1));
    o.degenerate = 1'b0;
    if (den[30:23] == 8'hFF || f32_real(den) <= f32_real(sed_pkg::DEN_FLOOR)) begin
      o.distance = sed_pkg::F32_POS_INF;
      o.degenerate = 1'b1;
      return o;
    end
    q = real_f32(f32_real(fmul(num, num)) / f32_real(den));
    if (q[30:23] == 8'hFF) o.distance = (q[22:0] != 0) ? sed_pkg::F32_QNAN : sed_pkg::F32_POS_INF;
    else if (q[31]) o.distance = 32'd0;
    else o.distance = real_f32($sqrt(f32_real(q)));
    return o;
  endfunction

  always @(posedge clk) begin
    sed_pkg::sed_out_t w;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (cfg_we) begin
        case (cfg_index)
          sed_pkg::CFG_PAIR_A: begin fmat[0] = cfg_data[31:0]; fmat[1] = cfg_data[63:32]; end
          sed_pkg::CFG_PAIR_B: begin fmat[2] = cfg_data[31:0]; fmat[3] = cfg_data[63:32]; end
          sed_pkg::CFG_PAIR_C: begin fmat[4] = cfg_data[31:0]; fmat[5] = cfg_data[63:32]; end
          sed_pkg::CFG_PAIR_D: begin fmat[6] = cfg_data[31:0]; fmat[7] = cfg_data[63:32]; end
          sed_pkg::CFG_LAST:   fmat[8] = cfg_data[31:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        dist_q.push_back(cur_typed ? cur_want : sampson_predict(corr));
        n_items++;
        idle_cycles = 0;
      end
      if (done) begin
        idle_cycles = 0;
        n_results++;
        if (dist_q.size() == 0) begin
          $error("result with no item outstanding: %h", result);
          fails++;
        end else begin
          w = dist_q.pop_front();
          if (w.degenerate) n_degen++;
          if (result.distance !== w.distance) begin
            $error("distance: expected %h, got %h", w.distance, result.distance);
            fails++;
          end
          if (result.degenerate !== w.degenerate) begin
            $error("degenerate: expected %b, got %b", w.degenerate, result.degenerate);
            fails++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sampson_epipolar_distance: mismatch");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] special_f32();
    logic [31:0] s [10];
    s = '{32'h0, 32'h80000000, sed_pkg::F32_POS_INF, 32'hFF800000, sed_pkg::F32_QNAN,
          32'h00000001, 32'h007FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000};
    return s[$urandom_range(0, 9)];
  endfunction

  function automatic logic [31:0] coord_f32(input bit wild);
    int k;
    k = $urandom_range(0, 99);
    if (wild && k < 20) return $urandom;
    if (wild && k < 30) return special_f32();
    return real_f32(real'($urandom_range(0, 2000000)) / 1000.0 - 1000.0);
  endfunction

  task automatic send_corr(input sed_pkg::sed_in_t c, input bit typed,
                           input sed_pkg::sed_out_t want);
    int g;
    @(negedge clk);
    start <= 1'b1;
    corr <= c;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (busy);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_matrix(input logic [31:0] m [9]);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sed_pkg::CFG_PAIR_A; cfg_data <= {m[1], m[0]};
    @(negedge clk);
    cfg_index <= sed_pkg::CFG_PAIR_B; cfg_data <= {m[3], m[2]};
    @(negedge clk);
    cfg_index <= sed_pkg::CFG_PAIR_C; cfg_data <= {m[5], m[4]};
    @(negedge clk);
    cfg_index <= sed_pkg::CFG_PAIR_D; cfg_data <= {m[7], m[6]};
    @(negedge clk);
    cfg_index <= sed_pkg::CFG_LAST; cfg_data <= {$urandom, m[8]};
    // unused index, must leave the matrix alone
    @(negedge clk);
    cfg_index <= 3'($urandom_range(5, 7)); cfg_data <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    corr_row_t         rows [$];
    logic [31:0]       m [9];
    sed_pkg::sed_out_t degen;
    sed_pkg::sed_in_t  c;
    int                kind;
    degen = '{distance: sed_pkg::F32_POS_INF, degenerate: 1'b1};
    foreach (fmat[i]) fmat[i] = 32'd0;

    // zero matrix after reset: every item is degenerate
    rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, degen});
    rows.push_back('{'{32'h3F800000, 32'h40000000, 32'h40400000, 32'h40800000}, 1'b1, degen});
    rows.push_back('{'{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF}, 1'b1, degen});
    rows.push_back('{'{sed_pkg::F32_POS_INF, 32'h0, 32'h0, 32'h0}, 1'b1, degen});
    rows.push_back('{'{32'h0, sed_pkg::F32_QNAN, 32'h0, 32'h0}, 1'b1, degen});
    rows.push_back('{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1, degen});
    rows.push_back('{'{32'h00000001, 32'h007FFFFF, 32'h80000001, 32'h00800000}, 1'b1, degen});
    foreach (rows[i]) send_corr(rows[i].pt, rows[i].typed, rows[i].want);
    settle();

    // skew-symmetric matrix [0 0 0; 0 0 -1; 0 1 0]
    m = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hBF800000, 32'h0, 32'h3F800000, 32'h0};
    load_matrix(m);
    rows.delete();
    rows.push_back('{'{32'h3F800000, 32'h40000000, 32'h3F800000, 32'h40000000}, 1'b0, degen});
    rows.push_back('{'{32'h3F800000, 32'h40000000, 32'h40400000, 32'h40A00000}, 1'b0, degen});
    rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, degen});
    rows.push_back('{'{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF}, 1'b0, degen});
    rows.push_back('{'{32'h00000001, 32'h00000001, 32'h00000001, 32'h80000001}, 1'b0, degen});
    rows.push_back('{'{32'h5F000000, 32'h5F000000, 32'h5F000000, 32'h5F000000}, 1'b0, degen});
    rows.push_back('{'{32'h0, sed_pkg::F32_POS_INF, 32'h0, 32'h3F800000}, 1'b0, degen});
    rows.push_back('{'{32'h0, sed_pkg::F32_QNAN, 32'h0, 32'h0}, 1'b0, degen});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, degen});
    rows.push_back('{'{32'h42C80000, 32'hC2C80000, 32'h3A83126F, 32'h007FFFFF}, 1'b0, degen});
    foreach (rows[i]) send_corr(rows[i].pt, rows[i].typed, rows[i].want);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      foreach (m[i]) begin
        case (ph)
          0: m[i] = 32'hFFFFFFFF;
          1: m[i] = 32'h7F7FFFFF;
          2: m[i] = $urandom;
          3: m[i] = (i % 2) ? 32'h00000001 : 32'h00800000;
          default: m[i] = ($urandom_range(0, 19) == 0) ? special_f32() :
                   real_f32((real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0)
                            / real'(10 ** $urandom_range(0, 4)));
        endcase
      end
      load_matrix(m);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        c.src_x = coord_f32(kind < 25);
        c.src_y = coord_f32(kind < 25);
        c.dst_x = coord_f32(kind < 25);
        c.dst_y = coord_f32(kind < 25);
        send_corr(c, 1'b0, degen);
      end
      settle();
    end

    $display("covered %0d correspondences over %0d matrix settings, %0d results checked",
             n_items, RANDOM_PHASES + 2, n_results);
    $display("%0d of them degenerate, with special and raw bit patterns mixed in", n_degen);
    if (fails == 0 && dist_q.size() == 0) begin
      $display("sampson_epipolar_distance: match");
    end else begin
      $display("sampson_epipolar_distance: mismatch");
    end
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule
